@@ design/bscff_pkg.sv @@
`timescale 1ns / 1ps

package bscff_pkg;

  localparam int WORD_BITS = 64;
  localparam int OFF_W     = 6;
  localparam int IDX_W     = 10;
  localparam int POS_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int MODE_W    = 3;

  localparam logic [SIZE_W-1:0]    SIZE_RESET = 11'd1024;
  localparam logic [WORD_BITS-1:0] WORD_ONES  = {WORD_BITS{1'b1}};
  localparam logic [WORD_BITS-1:0] WORD_ONE   = {{(WORD_BITS-1){1'b0}}, 1'b1};

  typedef enum logic [MODE_W-1:0] {
    OP_TEST      = 3'd0,
    OP_SET       = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_FIND_SET  = 3'd3,
    OP_FIND_ZERO = 3'd4,
    OP_CLEAR_ALL = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_SEARCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [OFF_W-1:0] off;
  } scan_res_t;

  // lowest set bit of a word
  function automatic logic [OFF_W-1:0] first_one(input logic [WORD_BITS-1:0] w);
    logic [OFF_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = OFF_W'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ design/bscff_ram.sv @@
`timescale 1ns / 1ps

module bscff_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/bscff_scan.sv @@
`timescale 1ns / 1ps

module bscff_scan (
  input  logic [bscff_pkg::WORD_BITS-1:0] data,
  input  logic                            want_set,
  input  logic [bscff_pkg::OFF_W-1:0]     low_off,
  input  logic                            hi_all,
  input  logic [bscff_pkg::OFF_W-1:0]     hi_off,
  output bscff_pkg::scan_res_t            res
);
  import bscff_pkg::*;

  logic [WORD_BITS-1:0] pol;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] cand;

  always_comb begin
    pol     = want_set ? data : ~data;
    lo_mask = WORD_ONES << low_off;
    // bits at or above the search limit are masked off in the last word
    hi_mask = hi_all ? WORD_ONES : ~(WORD_ONES << hi_off);
    cand    = pol & lo_mask & hi_mask;
    res.hit = |cand;
    res.off = first_one(cand);
  end

endmodule

@@ design/bitmap_set_clear_find_first.sv @@
`timescale 1ns / 1ps
// Test, set and clear: a read-modify-write state, then the result state; an index past the
// map goes straight to the result. in_stall stays high until the item's result is loaded.
// Searches: 64-bit words are scanned from the start word until a hit or the last word below
// the size limit, none when the start is at or past the size; the single read port gives
// one word a cycle. Clear all: a pass writes every word to zero, then the result. Synchronous
// reset starts a clearing pass with in_stall high; size_bits is 1024 at once.
module bitmap_set_clear_find_first #(
  parameter int MAP_BITS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bscff_pkg::MODE_W-1:0] mode,
  input  logic [bscff_pkg::IDX_W-1:0]  bit_addr,
  input  logic                         cfg_wr_en,
  input  logic [bscff_pkg::SIZE_W-1:0] cfg_wr_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [bscff_pkg::POS_W-1:0]  position,
  output logic                         bit_value
);
  import bscff_pkg::*;

  localparam int NWORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

  state_t state, state_next;

  logic [SIZE_W-1:0]    size_bits;
  op_t                  op;
  logic [OFF_W-1:0]     start_off;
  logic [SIZE_W-1:0]    lim;
  logic [AW-1:0]        cur_word;
  logic                 first_word;
  logic [AW-1:0]        clr_addr;
  logic                 clr_reply;
  logic                 res_found;
  logic [POS_W-1:0]     res_pos;
  logic                 res_val;

  logic                 in_acc;
  logic                 out_load;
  op_t                  in_op;
  logic [AW-1:0]        idx_word;
  logic                 idx_in_map;
  logic [SIZE_W-1:0]    lim_now;
  logic                 start_ok;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [WORD_BITS-1:0] bit_mask;
  logic [31:0]          next_base;
  logic [31:0]          lim_rem;
  logic                 last_word;
  logic [OFF_W-1:0]     low_off;
  logic                 hi_all;
  scan_res_t            scan;

  assign in_op      = op_t'(mode);
  assign idx_word   = AW'(bit_addr >> OFF_W);
  assign idx_in_map = 32'(bit_addr) < 32'(MAP_BITS);
  assign lim_now    = (32'(size_bits) > 32'(MAP_BITS)) ? SIZE_W'(MAP_BITS) : size_bits;
  assign start_ok   = 32'(bit_addr) < 32'(lim_now);
  assign in_acc     = in_valid && !in_stall;

  // search bookkeeping for the word now on the memory output
  assign next_base = (32'(cur_word) + 32'd1) << OFF_W;
  assign lim_rem   = 32'(lim) - (32'(cur_word) << OFF_W);
  assign last_word = next_base >= 32'(lim);
  assign hi_all    = !(next_base > 32'(lim));
  assign low_off   = first_word ? start_off : '0;
  assign bit_mask  = WORD_ONE << start_off;

  bscff_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bscff_scan u_scan (
    .data     (ram_rdata),
    .want_set (op == OP_FIND_SET),
    .low_off  (low_off),
    .hi_all   (hi_all),
    .hi_off   (lim_rem[OFF_W-1:0]),
    .res      (scan)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_WORD) begin
          state_next = clr_reply ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_TEST, OP_SET, OP_CLEAR: state_next = idx_in_map ? S_RMW : S_DONE;
            OP_FIND_SET, OP_FIND_ZERO: state_next = start_ok ? S_SEARCH : S_DONE;
            OP_CLEAR_ALL:              state_next = S_CLEAR;
            default:                   state_next = S_DONE;
          endcase
        end
      end
      S_RMW: state_next = S_DONE;
      S_SEARCH: begin
        if (scan.hit || last_word) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = cur_word;
    ram_wdata = '0;
    ram_raddr = idx_word;
    out_load  = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      S_IDLE: in_stall = 1'b0;
      S_RMW: begin
        ram_we    = (op == OP_SET) || (op == OP_CLEAR);
        ram_wdata = (op == OP_SET) ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
      end
      S_SEARCH: ram_raddr = cur_word + AW'(1);
      S_DONE:   out_load  = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      size_bits <= SIZE_RESET;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        size_bits <= cfg_wr_data;
      end
      if (state == S_CLEAR) begin
        clr_addr <= (clr_addr == LAST_WORD) ? '0 : clr_addr + AW'(1);
      end
      if (in_acc && in_op == OP_CLEAR_ALL) begin
        clr_reply <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op         <= in_op;
      start_off  <= bit_addr[OFF_W-1:0];
      lim        <= lim_now;
      cur_word   <= idx_word;
      first_word <= 1'b1;
      res_found  <= 1'b0;
      res_pos    <= '0;
      res_val    <= 1'b0;
    end
    if (state == S_RMW) begin
      case (op)
        OP_SET:   res_val <= 1'b1;
        OP_CLEAR: res_val <= 1'b0;
        default:  res_val <= ram_rdata[start_off];
      endcase
    end
    if (state == S_SEARCH) begin
      first_word <= 1'b0;
      if (scan.hit) begin
        res_found <= 1'b1;
        res_pos   <= POS_W'((32'(cur_word) << OFF_W) | 32'(scan.off));
      end else if (!last_word) begin
        cur_word <= cur_word + AW'(1);
      end
    end
    if (out_load) begin
      found     <= res_found;
      position  <= res_pos;
      bit_value <= res_val;
    end
  end

endmodule

@@ design/bscff_checker.sv @@
`timescale 1ns / 1ps

module bscff_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         found,
  input logic [bscff_pkg::POS_W-1:0]  position,
  input logic                         bit_value
);
  import bscff_pkg::*;

  // a held result item keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(position)
      && $stable(bit_value))
    else $error("result item changed while stalled");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> position == '0)
    else $error("position nonzero without a find");

  a_found_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> !bit_value)
    else $error("found and bit_value both set");

  // the map clearing pass keeps the input stalled right after reset
  a_rst_sweep: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input not stalled after reset");

endmodule

bind bitmap_set_clear_find_first bscff_checker u_chk (.*);
